// ===== rtl/core/hsvrgb_pkg.sv =====
// Package for the HSV to RGB converter: field widths, hue sector codes
// and the divide-by-full-scale helper. No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Field widths, fixed by the stream format
    localparam int HUE_W     = 15;
    localparam int CHAN_W    = 8;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

    // Hue geometry, in whole degrees
    localparam int HUE_FRACTION_BITS_DEF = 6;
    localparam int HUE_INT_BITS          = 9;
    localparam int SECTOR_DEG            = 60;
    localparam int TURN_DEG              = 360;
    localparam int NUM_SECTORS           = 6;

    localparam int NUM_ST = 8;

    // Sector codes, named by largest then middle channel
    typedef logic [2:0] t_sector;
    localparam t_sector SEC_RED_GREEN  = 3'd0;
    localparam t_sector SEC_GREEN_RED  = 3'd1;
    localparam t_sector SEC_GREEN_BLUE = 3'd2;
    localparam t_sector SEC_BLUE_GREEN = 3'd3;
    localparam t_sector SEC_BLUE_RED   = 3'd4;
    localparam t_sector SEC_RED_BLUE   = 3'd5;

    // Exact floor(y / (2^CHAN_W - 1)) for y up to CHAN_MAX squared
    function automatic logic [CHAN_W-1:0] div_by_max(input logic [PROD_W-1:0] y);
        logic [PROD_W:0] t;
        t = {1'b0, y} + (PROD_W+1)'(y[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level: eight-stage pipeline with stream ports.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

// Converts one HSV pixel per item to 8-bit RGB. Input tdata carries hue in
// 1/2^HUE_FRACTION_BITS degree units, saturation and value as fractions of
// 255; output tdata carries red, green and blue, each the exact floor of the
// real result. Hue at or past a full turn is first masked to
// 9+HUE_FRACTION_BITS bits and then wrapped once by 360 degrees. The block
// takes one item every clock unless every slot is full and the output stalls;
// it is built of eight register stages (hue wrap, sector search and
// the two chroma products, ramp fold, ramp product, reciprocal multiply for
// the divide by 60, remainder, correction and sum, final divide by 255 and
// channel routing). Each stage holds only when the stage after it is full
// and stalled, so empty slots close up and the input stays ready while a
// result waits at the output, as long as a slot is free.
module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // hue[14:0], saturation[22:15], brightness[30:23], zero pad[31]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int SPAN   = SECTOR_DEG * (2 ** HUE_FRACTION_BITS);
    localparam int TURN   = TURN_DEG * (2 ** HUE_FRACTION_BITS);
    localparam int MASK_B = HUE_INT_BITS + HUE_FRACTION_BITS;
    localparam logic [HUE_W-1:0] HUE_MASK = (MASK_B >= HUE_W) ? {HUE_W{1'b1}} :
        HUE_W'((32'd1 << MASK_B) - 32'd1);
    localparam int PW = $clog2(2 * SPAN);            // folded hue position
    localparam int FW = $clog2(SPAN + 1);            // ramp, 0..SPAN
    localparam int XW = PROD_W + FW - HUE_FRACTION_BITS; // ramp product >> frac
    localparam int RW = XW - 5;                      // reciprocal of 60
    localparam longint RECIP = (64'd1 << XW) / SECTOR_DEG;
    localparam int REM_W = 7;                        // remainder < 120

    // Stage enables and valid bits
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] w_en;

    always_comb begin
        w_en[NUM_ST-1] = !r_vld[NUM_ST-1] || m_axis_tready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NUM_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: mask and wrap hue
    logic [HUE_W-1:0]  w_hue_m;
    logic [HUE_W-1:0]  n1_hue;
    logic [HUE_W-1:0]  r1_hue;
    logic [CHAN_W-1:0] r1_s, r1_v;

    always_comb begin
        w_hue_m = s_axis_tdata[HUE_W-1:0] & HUE_MASK;
        if (32'(w_hue_m) >= 32'(TURN)) begin
            n1_hue = w_hue_m - HUE_W'(TURN);
        end else begin
            n1_hue = w_hue_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_hue <= n1_hue;
            r1_s   <= s_axis_tdata[HUE_W+CHAN_W-1:HUE_W];
            r1_v   <= s_axis_tdata[HUE_W+2*CHAN_W-1:HUE_W+CHAN_W];
        end
    end

    // Stage 2: sector search, position in the 120-degree span, chroma terms
    t_sector           n2_sector, r2_sector;
    logic [31:0]       w_base;
    logic [PW-1:0]     n2_p, r2_p;
    logic [PROD_W-1:0] r2_sv, r2_vc;
    logic [CHAN_W-1:0] r2_v;

    always_comb begin
        n2_sector = SEC_RED_GREEN;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (32'(r1_hue) >= 32'(k * SPAN)) begin
                n2_sector = n2_sector + 3'd1;
            end
        end
        case (n2_sector) inside
            SEC_RED_GREEN, SEC_GREEN_RED:  w_base = 32'd0;
            SEC_GREEN_BLUE, SEC_BLUE_GREEN: w_base = 32'(2 * SPAN);
            default:                        w_base = 32'(4 * SPAN);
        endcase
        n2_p = PW'(32'(r1_hue) - w_base);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_sector <= n2_sector;
            r2_p      <= n2_p;
            r2_sv     <= PROD_W'(r1_s) * PROD_W'(r1_v);
            r2_vc     <= PROD_W'(r1_v) * PROD_W'(CHAN_MAX - r1_s);
            r2_v      <= r1_v;
        end
    end

    // Stage 3: fold position into the ramp, smallest channel
    t_sector           r3_sector;
    logic [FW-1:0]     n3_f, r3_f;
    logic [PROD_W-1:0] r3_sv, r3_vc;
    logic [CHAN_W-1:0] r3_v, r3_lo;

    always_comb begin
        if (32'(r2_p) >= 32'(SPAN)) begin
            n3_f = FW'(32'(2 * SPAN) - 32'(r2_p));
        end else begin
            n3_f = FW'(r2_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_sector <= r2_sector;
            r3_f      <= n3_f;
            r3_sv     <= r2_sv;
            r3_vc     <= r2_vc;
            r3_v      <= r2_v;
            r3_lo     <= div_by_max(r2_vc);
        end
    end

    // Stage 4: ramp product, drop the hue fraction
    logic [PROD_W+FW-1:0] w_svf;
    t_sector              r4_sector;
    logic [XW-1:0]        r4_x;
    logic [PROD_W-1:0]    r4_vc;
    logic [CHAN_W-1:0]    r4_v, r4_lo;

    assign w_svf = (PROD_W+FW)'(r3_sv) * (PROD_W+FW)'(r3_f);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_sector <= r3_sector;
            r4_x      <= w_svf[PROD_W+FW-1:HUE_FRACTION_BITS];
            r4_vc     <= r3_vc;
            r4_v      <= r3_v;
            r4_lo     <= r3_lo;
        end
    end

    // Stage 5: quotient estimate by 60, low by at most one
    logic [XW+RW-1:0]  w_qprod;
    t_sector           r5_sector;
    logic [XW-1:0]     r5_x;
    logic [RW-1:0]     r5_q0;
    logic [PROD_W-1:0] r5_vc;
    logic [CHAN_W-1:0] r5_v, r5_lo;

    assign w_qprod = (XW+RW)'(r4_x) * (XW+RW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_sector <= r4_sector;
            r5_x      <= r4_x;
            r5_q0     <= w_qprod[XW+RW-1:XW];
            r5_vc     <= r4_vc;
            r5_v      <= r4_v;
            r5_lo     <= r4_lo;
        end
    end

    // Stage 6: remainder of the estimate
    logic [XW-1:0]     w_rem_full;
    t_sector           r6_sector;
    logic [RW-1:0]     r6_q0;
    logic [REM_W-1:0]  r6_rem;
    logic [PROD_W-1:0] r6_vc;
    logic [CHAN_W-1:0] r6_v, r6_lo;

    assign w_rem_full = r5_x - XW'(r5_q0) * XW'(SECTOR_DEG);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_sector <= r5_sector;
            r6_q0     <= r5_q0;
            r6_rem    <= w_rem_full[REM_W-1:0];
            r6_vc     <= r5_vc;
            r6_v      <= r5_v;
            r6_lo     <= r5_lo;
        end
    end

    // Stage 7: correct the quotient, add the offset term
    logic [PROD_W:0]   w_ysum;
    t_sector           r7_sector;
    logic [PROD_W-1:0] r7_y;
    logic [CHAN_W-1:0] r7_v, r7_lo;

    assign w_ysum = {1'b0, r6_vc} + (PROD_W+1)'(r6_q0)
                  + (PROD_W+1)'(r6_rem >= REM_W'(SECTOR_DEG));

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_sector <= r6_sector;
            r7_y      <= w_ysum[PROD_W-1:0];
            r7_v      <= r6_v;
            r7_lo     <= r6_lo;
        end
    end

    // Stage 8: middle channel, route (hi, mid, lo) by sector
    logic [CHAN_W-1:0] w_mid;
    logic [CHAN_W-1:0] n8_r, n8_g, n8_b;
    logic [CHAN_W-1:0] r8_r, r8_g, r8_b;

    always_comb begin
        w_mid = div_by_max(r7_y);
        case (r7_sector)
            SEC_RED_GREEN:  begin n8_r = r7_v;  n8_g = w_mid; n8_b = r7_lo; end
            SEC_GREEN_RED:  begin n8_r = w_mid; n8_g = r7_v;  n8_b = r7_lo; end
            SEC_GREEN_BLUE: begin n8_r = r7_lo; n8_g = r7_v;  n8_b = w_mid; end
            SEC_BLUE_GREEN: begin n8_r = r7_lo; n8_g = w_mid; n8_b = r7_v;  end
            SEC_BLUE_RED:   begin n8_r = w_mid; n8_g = r7_lo; n8_b = r7_v;  end
            default:        begin n8_r = r7_v;  n8_g = r7_lo; n8_b = w_mid; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_r <= n8_r;
            r8_g <= n8_g;
            r8_b <= n8_b;
        end
    end

    assign m_axis_tdata = {r8_b, r8_g, r8_r};

`ifndef NO_ASSERTIONS
    // Sector search never runs past the last sector
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r2_sector <= SEC_RED_BLUE))
        else $error("hue sector out of range");

    // Folded ramp stays within one sector span
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (32'(r3_f) <= 32'(SPAN)))
        else $error("hue ramp above sector span");

    // Reciprocal estimate is off by at most one step
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r6_rem < REM_W'(2 * SECTOR_DEG)))
        else $error("divide by 60 needs more than one correction");

    // Middle-channel numerator never exceeds brightness at full scale
    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r7_y <= PROD_W'(r7_v) * PROD_W'(CHAN_MAX)))
        else $error("middle channel above brightness");

    // Input holds off only when every slot is full and the output stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&r_vld)))
        else $error("input stalled with a free slot");
`endif

endmodule
